### src/rdpp_pkg.sv
package rdpp_pkg;

    // Default panel geometry
    localparam int PANEL_WIDTH_DEF    = 152;
    localparam int PANEL_HEIGHT_DEF   = 296;
    localparam int BYTES_PER_LINE_DEF = 19;

    // Pixel mask for the leftmost pixel of a byte (MSB first)
    localparam logic [7:0] LEFT_BIT = 8'h80;

    // Operation codes of an input beat
    localparam logic [1:0] OP_PLOT  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Orientation codes
    localparam logic [1:0] ORIENT_0   = 2'd0;
    localparam logic [1:0] ORIENT_90  = 2'd1;
    localparam logic [1:0] ORIENT_180 = 2'd2;
    localparam logic [1:0] ORIENT_270 = 2'd3;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROT    = 5'b00010,
        ST_ADDR   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_CLEAR  = 5'b10000
    } state_t;

    // Address-mapping status handed to the sequencer
    typedef struct packed {
        logic       clip;
        logic [7:0] mask;
    } xlate_t;

endpackage

### src/rdpp_ram.sv
module rdpp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5624
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/rdpp_xlate.sv
module rdpp_xlate import rdpp_pkg::*; #(
    parameter int PANEL_WIDTH    = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT   = PANEL_HEIGHT_DEF,
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF,
    parameter int ADDR_W         = $clog2(BYTES_PER_LINE * PANEL_HEIGHT)
) (
    input  logic              aclk,
    input  logic              rot_en,
    input  logic [1:0]        orientation,
    input  logic [1:0]        operation,
    input  logic [15:0]       x_coord,
    input  logic [15:0]       y_coord,
    input  logic [12:0]       byte_index,
    output logic [ADDR_W-1:0] addr,
    output xlate_t            info
);

    localparam int PLANE_BYTES = BYTES_PER_LINE * PANEL_HEIGHT;
    localparam int LIN_W       = $clog2(PLANE_BYTES + PANEL_WIDTH);
    localparam logic [15:0] W_LAST = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] H_LAST = 16'(PANEL_HEIGHT - 1);

    logic [15:0]      rx_next, ry_next;
    logic [15:0]      rx_reg, ry_reg;
    logic [15:0]      col;
    logic [LIN_W-1:0] lin_addr;
    logic             off_panel;

    // Rotation, wrapping modulo 2^16
    always_comb begin
        unique case (orientation)
            ORIENT_90: begin
                rx_next = H_LAST - y_coord;
                ry_next = x_coord;
            end
            ORIENT_180: begin
                rx_next = W_LAST - x_coord;
                ry_next = H_LAST - y_coord;
            end
            ORIENT_270: begin
                rx_next = y_coord;
                ry_next = W_LAST - x_coord;
            end
            default: begin
                rx_next = x_coord;
                ry_next = y_coord;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rot_en) begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    // Row-major byte address of the rotated pixel
    assign col       = rx_reg >> 3;
    assign lin_addr  = LIN_W'(ry_reg) * LIN_W'(BYTES_PER_LINE) + LIN_W'(col);
    assign off_panel = (rx_reg >= 16'(PANEL_WIDTH)) || (ry_reg >= 16'(PANEL_HEIGHT))
                       || (lin_addr >= LIN_W'(PLANE_BYTES));

    // Address and clip per operation
    always_comb begin
        info.mask = LEFT_BIT >> rx_reg[2:0];
        case (operation)
            OP_PLOT: begin
                addr      = lin_addr[ADDR_W-1:0];
                info.clip = off_panel;
            end
            OP_READ: begin
                addr      = ADDR_W'(byte_index);
                info.clip = 32'(byte_index) >= 32'(PLANE_BYTES);
            end
            default: begin
                addr      = '0;
                info.clip = 1'b0;
            end
        endcase
    end

endmodule

### src/rotated_dual_plane_pixel_plotter.sv
// Two 1-bit-per-pixel planes (black/white and red), packed MSB first, held
// side by side in one 16-bit-wide RAM of BYTES_PER_LINE*PANEL_HEIGHT entries.
// Plot and read beats: the rotation is registered, then the RAM is read, then
// the byte pair is modified, written back and the result registered; the
// write-back stalls while the output register is full. A clear beat sweeps
// the RAM one entry per cycle over all BYTES_PER_LINE*PANEL_HEIGHT entries
// (5624 by default), then finishes like the other beats. After reset the same
// sweep runs once with s_ready low; orientation writes are taken at any time.
// A finished result waits in the output register while the next beat is
// accepted and worked on; it only stalls at its write-back.
module rotated_dual_plane_pixel_plotter import rdpp_pkg::*; #(
    parameter int PANEL_WIDTH    = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT   = PANEL_HEIGHT_DEF,
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_x_coord,
    input  logic [15:0] s_y_coord,
    input  logic        s_bw_bit,
    input  logic        s_red_bit,
    input  logic [12:0] s_byte_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_bw_byte,
    output logic [7:0]  m_red_byte,
    output logic        m_clipped
);

    localparam int PLANE_BYTES = BYTES_PER_LINE * PANEL_HEIGHT;
    localparam int ADDR_W      = $clog2(PLANE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_BYTES - 1);

    state_t state_reg, state_next;
    logic   init_reg, init_next;
    logic [1:0] orient_reg;
    logic [ADDR_W-1:0] clear_reg, clear_next;

    // Captured input beat
    logic [1:0]  op_reg;
    logic [15:0] x_reg, y_reg;
    logic        bw_bit_reg, red_bit_reg;
    logic [12:0] idx_reg;

    // Address-mapping results
    logic [ADDR_W-1:0] xl_addr, addr_reg;
    xlate_t            xl_info, info_reg;

    // RAM ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [15:0]       wr_data, rd_data;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] bw_byte_reg, red_byte_reg;
    logic [7:0] bw_byte_next, red_byte_next;
    logic       clipped_reg, clipped_next;
    logic       slot_free;
    logic [7:0] bw_new, red_new;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    // Orientation register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg <= ORIENT_0;
        end else if (cfg_we) begin
            orient_reg <= cfg_wdata;
        end
    end

    // Capture the beat on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= s_operation;
            x_reg       <= s_x_coord;
            y_reg       <= s_y_coord;
            bw_bit_reg  <= s_bw_bit;
            red_bit_reg <= s_red_bit;
            idx_reg     <= s_byte_index;
        end
    end

    rdpp_xlate #(
        .PANEL_WIDTH    (PANEL_WIDTH),
        .PANEL_HEIGHT   (PANEL_HEIGHT),
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .ADDR_W         (ADDR_W)
    ) u_xlate (
        .aclk        (aclk),
        .rot_en      (state_reg == ST_ROT),
        .orientation (orient_reg),
        .operation   (op_reg),
        .x_coord     (x_reg),
        .y_coord     (y_reg),
        .byte_index  (idx_reg),
        .addr        (xl_addr),
        .info        (xl_info)
    );

    // Hold the mapped address while the read data is consumed
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADDR) begin
            addr_reg <= xl_addr;
            info_reg <= xl_info;
        end
    end

    // Read-modify-write of the byte pair, or zero fill during a sweep
    assign bw_new  = bw_bit_reg  ? (rd_data[15:8] | info_reg.mask)
                                 : (rd_data[15:8] & ~info_reg.mask);
    assign red_new = red_bit_reg ? (rd_data[7:0] | info_reg.mask)
                                 : (rd_data[7:0] & ~info_reg.mask);
    assign rd_addr = (state_reg == ST_ADDR) ? xl_addr : addr_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = {bw_new, red_new};
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clear_reg;
            wr_data = '0;
        end else if (state_reg == ST_FINISH && slot_free && op_reg == OP_PLOT
                     && !info_reg.clip) begin
            wr_en = 1'b1;
        end
    end

    rdpp_ram #(
        .WIDTH (16),
        .DEPTH (PLANE_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        init_next  = init_reg;
        clear_next = clear_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_operation == OP_CLEAR) ? ST_CLEAR : ST_ROT;
                end
            end
            ST_ROT: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (clear_reg == LAST_ADDR) begin
                    clear_next = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_FINISH;
                end else begin
                    clear_next = clear_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            init_reg  <= 1'b1;
            clear_reg <= '0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clear_reg <= clear_next;
        end
    end

    // Result register
    assign m_valid_next = (state_reg == ST_FINISH && slot_free) ? 1'b1
                        : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result fields per operation
    always_comb begin
        bw_byte_next  = '0;
        red_byte_next = '0;
        clipped_next  = 1'b0;
        case (op_reg)
            OP_PLOT: begin
                clipped_next = info_reg.clip;
            end
            OP_READ: begin
                clipped_next = info_reg.clip;
                if (!info_reg.clip) begin
                    bw_byte_next  = rd_data[15:8];
                    red_byte_next = rd_data[7:0];
                end
            end
            default: begin
                clipped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && slot_free) begin
            bw_byte_reg  <= bw_byte_next;
            red_byte_reg <= red_byte_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_bw_byte  = bw_byte_reg;
    assign m_red_byte = red_byte_reg;
    assign m_clipped  = clipped_reg;

    // Checks
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("RAM written while idle");

    a_sweep_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (wr_en && wr_data == '0 && wr_addr == clear_reg))
        else $error("clear sweep not writing zeros at sweep address");

    a_sweep_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (clear_reg == '0 && !init_reg))
        else $error("idle with sweep unfinished");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside write-back");

    // only an on-panel plot has read data that the write-back depends on
    a_finish_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !slot_free && op_reg == OP_PLOT && !info_reg.clip)
            |=> (state_reg == ST_FINISH && $stable(rd_data)))
        else $error("stalled write-back lost its read data");

endmodule

### test/rdpp_plane_check.sv
// Watches both channels of the pixel plotter, keeps its own copy of the two
// planes and the orientation, and compares every result beat in order.
module rdpp_plane_check import rdpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_x_coord,
    input  logic [15:0] s_y_coord,
    input  logic        s_bw_bit,
    input  logic        s_red_bit,
    input  logic [12:0] s_byte_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_bw_byte,
    input  logic [7:0]  m_red_byte,
    input  logic        m_clipped,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PLANE_BYTES = BYTES_PER_LINE_DEF * PANEL_HEIGHT_DEF;
    localparam logic [15:0] X_LAST      = 16'(PANEL_WIDTH_DEF - 1);
    localparam logic [15:0] Y_LAST      = 16'(PANEL_HEIGHT_DEF - 1);

    typedef struct packed {
        logic [7:0] bw_byte;
        logic [7:0] red_byte;
        logic       clipped;
    } pixel_beat_t;

    logic [7:0]  bw_shadow  [PLANE_BYTES];
    logic [7:0]  red_shadow [PLANE_BYTES];
    logic [1:0]  orientation;
    pixel_beat_t expected_beats [$];
    int          results_seen;

    task automatic report_mismatch(input string what);
        $display("%0t ns: result beat %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    // Applies one input beat to the shadow planes and returns its result beat
    function automatic pixel_beat_t framebuffer_beat(input logic [1:0]  op,
                                                     input logic [15:0] x,
                                                     input logic [15:0] y,
                                                     input logic        bw,
                                                     input logic        red,
                                                     input logic [12:0] idx);
        pixel_beat_t r;
        logic [15:0] px;
        logic [15:0] py;
        int          addr;
        logic [7:0]  mask;
        r = '0;
        case (op)
            OP_PLOT: begin
                // panel coordinates, subtraction wraps at 16 bits
                case (orientation)
                    ORIENT_90:  begin px = Y_LAST - y; py = x;          end
                    ORIENT_180: begin px = X_LAST - x; py = Y_LAST - y; end
                    ORIENT_270: begin px = y;          py = X_LAST - x; end
                    default:    begin px = x;          py = y;          end
                endcase
                if (px >= PANEL_WIDTH_DEF || py >= PANEL_HEIGHT_DEF) begin
                    r.clipped = 1'b1;
                end else begin
                    addr = py * BYTES_PER_LINE_DEF + (px >> 3);
                    mask = LEFT_BIT >> px[2:0];
                    bw_shadow[addr]  = bw  ? (bw_shadow[addr] | mask)
                                           : (bw_shadow[addr] & ~mask);
                    red_shadow[addr] = red ? (red_shadow[addr] | mask)
                                           : (red_shadow[addr] & ~mask);
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < PLANE_BYTES; i++) begin
                    bw_shadow[i]  = '0;
                    red_shadow[i] = '0;
                end
            end
            OP_READ: begin
                if (idx >= PLANE_BYTES) begin
                    r.clipped = 1'b1;
                end else begin
                    r.bw_byte  = bw_shadow[idx];
                    r.red_byte = red_shadow[idx];
                end
            end
            default: ;  // unused code: no change, all zero
        endcase
        return r;
    endfunction

    // Sample both channels at the rising edge; results are checked before the
    // new input beat is queued
    always @(posedge aclk) begin
        pixel_beat_t want;
        if (!aresetn) begin
            for (int i = 0; i < PLANE_BYTES; i++) begin
                bw_shadow[i]  = '0;
                red_shadow[i] = '0;
            end
            orientation = ORIENT_0;
            expected_beats.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (cfg_we) begin
                orientation = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_beats.pop_front();
                    if (m_bw_byte !== want.bw_byte)
                        report_mismatch($sformatf("bw_byte %02h, expected %02h",
                                                  m_bw_byte, want.bw_byte));
                    if (m_red_byte !== want.red_byte)
                        report_mismatch($sformatf("red_byte %02h, expected %02h",
                                                  m_red_byte, want.red_byte));
                    if (m_clipped !== want.clipped)
                        report_mismatch($sformatf("clipped %b, expected %b",
                                                  m_clipped, want.clipped));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                expected_beats.push_back(framebuffer_beat(s_operation, s_x_coord,
                                                          s_y_coord, s_bw_bit,
                                                          s_red_bit, s_byte_index));
            end
        end
        outstanding = expected_beats.size();
    end

endmodule

### test/rotated_dual_plane_pixel_plotter_tb.sv
module rotated_dual_plane_pixel_plotter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rdpp_pkg::*;

    localparam int          PLANE_BYTES = BYTES_PER_LINE_DEF * PANEL_HEIGHT_DEF;
    localparam logic [15:0] X_LAST      = 16'(PANEL_WIDTH_DEF - 1);
    localparam logic [15:0] Y_LAST      = 16'(PANEL_HEIGHT_DEF - 1);
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          PHASE_BEATS = 72;
    localparam int          STALL_AFTER = 120;   // result count at the long hold-off
    localparam int          STALL_LONG  = 400;
    localparam int          IDLE_LIMIT  = 20000; // covers a full clear sweep
    localparam int          TAIL_CYCLES = 20;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [15:0] s_x_coord;
    logic [15:0] s_y_coord;
    logic        s_bw_bit;
    logic        s_red_bit;
    logic [12:0] s_byte_index;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_bw_byte;
    logic [7:0]  m_red_byte;
    logic        m_clipped;

    int          mismatches;
    int          outstanding;
    int          idle_cycles;
    int          tx_calm;
    int          rx_calm;
    logic [1:0]  orient_now;
    logic [15:0] last_px;
    logic [15:0] last_py;
    int          recent_bytes [$];

    rotated_dual_plane_pixel_plotter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_x_coord    (s_x_coord),
        .s_y_coord    (s_y_coord),
        .s_bw_bit     (s_bw_bit),
        .s_red_bit    (s_red_bit),
        .s_byte_index (s_byte_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bw_byte    (m_bw_byte),
        .m_red_byte   (m_red_byte),
        .m_clipped    (m_clipped)
    );

    rdpp_plane_check plane_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_x_coord    (s_x_coord),
        .s_y_coord    (s_y_coord),
        .s_bw_bit     (s_bw_bit),
        .s_red_bit    (s_red_bit),
        .s_byte_index (s_byte_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bw_byte    (m_bw_byte),
        .m_red_byte   (m_red_byte),
        .m_clipped    (m_clipped),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // 100 MHz clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Idle gap per beat, with runs of back-to-back beats
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 7) == 0) calm = $urandom_range(10, 40);
        end
    endtask

    // Offers one input beat and returns at the edge that takes it
    task automatic send_beat(input logic [1:0]  op,
                             input logic [15:0] x,
                             input logic [15:0] y,
                             input logic        bw,
                             input logic        red,
                             input logic [12:0] idx);
        int gap;
        @(negedge aclk);
        draw_gap(tx_calm, gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation  <= op;
        s_x_coord    <= x;
        s_y_coord    <= y;
        s_bw_bit     <= bw;
        s_red_bit    <= red;
        s_byte_index <= idx;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Plot aimed at a panel position: map it back to logical coordinates
    task automatic plot_at(input logic [15:0] px, input logic [15:0] py,
                           input logic bw, input logic red);
        logic [15:0] lx;
        logic [15:0] ly;
        case (orient_now)
            ORIENT_90:  begin lx = py;          ly = Y_LAST - px; end
            ORIENT_180: begin lx = X_LAST - px; ly = Y_LAST - py; end
            ORIENT_270: begin lx = X_LAST - py; ly = px;          end
            default:    begin lx = px;          ly = py;          end
        endcase
        if (px < PANEL_WIDTH_DEF && py < PANEL_HEIGHT_DEF) begin
            recent_bytes.push_back(py * BYTES_PER_LINE_DEF + (px >> 3));
            if (recent_bytes.size() > 32) void'(recent_bytes.pop_front());
        end
        send_beat(OP_PLOT, lx, ly, bw, red, 13'($urandom));
    endtask

    task automatic read_at(input int idx);
        send_beat(OP_READ, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                  13'(idx));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic set_orientation(input logic [1:0] o);
        @(negedge aclk);
        cfg_wdata  <= o;
        cfg_we     <= 1'b1;
        orient_now  = o;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random beats: mostly on-panel plots and reads of recently drawn bytes
    task automatic random_beats(input int count);
        int          kind;
        int          pick;
        logic [15:0] px;
        logic [15:0] py;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                if ($urandom_range(0, 2) == 0) begin
                    // same byte as the last plot, any pixel in it
                    px = 16'((last_px & 16'hFFF8) | $urandom_range(0, 7));
                    py = last_py;
                end else begin
                    px = 16'($urandom_range(0, PANEL_WIDTH_DEF - 1));
                    py = 16'($urandom_range(0, PANEL_HEIGHT_DEF - 1));
                end
                last_px = px;
                last_py = py;
                plot_at(px, py, 1'($urandom), 1'($urandom));
            end else if (kind < 55) begin
                // panel border, just outside it, and wrapped negatives
                case ($urandom_range(0, 3))
                    0:       px = 16'd0;
                    1:       px = X_LAST;
                    2:       px = 16'(PANEL_WIDTH_DEF);
                    default: px = 16'hFFFF;
                endcase
                case ($urandom_range(0, 3))
                    0:       py = 16'd0;
                    1:       py = Y_LAST;
                    2:       py = 16'(PANEL_HEIGHT_DEF);
                    default: py = 16'hFFFF;
                endcase
                plot_at(px, py, 1'($urandom), 1'($urandom));
            end else if (kind < 63) begin
                send_beat(OP_PLOT, 16'($urandom), 16'($urandom), 1'($urandom),
                          1'($urandom), 13'($urandom));
            end else if (kind < 96) begin
                pick = $urandom_range(0, 9);
                if (pick < 4 && recent_bytes.size() > 0)
                    read_at(recent_bytes[recent_bytes.size() - 1]);
                else if (pick < 7 && recent_bytes.size() > 0)
                    read_at(recent_bytes[$urandom_range(0, recent_bytes.size() - 1)]);
                else
                    read_at($urandom_range(0, 8191));
            end else if (kind < 98) begin
                send_beat(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
                          1'($urandom), 13'($urandom));
            end else begin
                send_beat(OP_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom),
                          1'($urandom), 13'($urandom));
            end
        end
    endtask

    task automatic run_phase(input logic [1:0] o);
        set_orientation(o);
        random_beats(PHASE_BEATS);
        drain_results();
    endtask

    // Stimulus
    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_operation  = OP_PLOT;
        s_x_coord    = '0;
        s_y_coord    = '0;
        s_bw_bit     = 1'b0;
        s_red_bit    = 1'b0;
        s_byte_index = '0;
        tx_calm      = 0;
        rx_calm      = 0;
        orient_now   = ORIENT_0;
        last_px      = '0;
        last_py      = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: corners, byte edges, clipping, clear and the unused code
        set_orientation(ORIENT_0);
        read_at(0);
        plot_at(16'd0, 16'd0, 1'b1, 1'b0);
        plot_at(X_LAST, Y_LAST, 1'b1, 1'b1);
        plot_at(16'd7, 16'd0, 1'b0, 1'b1);
        plot_at(16'd8, 16'd0, 1'b1, 1'b1);
        read_at(0);
        read_at(1);
        read_at(PLANE_BYTES - 1);
        plot_at(16'(PANEL_WIDTH_DEF), 16'd0, 1'b1, 1'b1);
        plot_at(16'd0, 16'(PANEL_HEIGHT_DEF), 1'b1, 1'b1);
        plot_at(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        read_at(PLANE_BYTES);
        read_at(8191);
        plot_at(16'd0, 16'd0, 1'b0, 1'b0);
        read_at(0);
        send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 13'h1FFF);
        send_beat(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 13'h1FFF);
        read_at(PLANE_BYTES - 1);
        read_at(0);
        drain_results();

        // random phases over every orientation
        run_phase(ORIENT_90);
        run_phase(ORIENT_180);
        run_phase(ORIENT_270);
        run_phase(ORIENT_0);
        run_phase(ORIENT_270);
        run_phase(ORIENT_90);

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (taken == STALL_AFTER) gap = STALL_LONG;
            else draw_gap(rx_calm, gap);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    // Watchdog: too long with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

### filelist.f
src/rdpp_pkg.sv
src/rdpp_ram.sv
src/rdpp_xlate.sv
src/rotated_dual_plane_pixel_plotter.sv
test/rdpp_plane_check.sv
test/rotated_dual_plane_pixel_plotter_tb.sv
